>>> sv/random_sample_set_unit_defines.svh
// Assertion macros for the random sample set unit
`ifndef RANDOM_SAMPLE_SET_UNIT_DEFINES_SVH
`define RANDOM_SAMPLE_SET_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("random sample set check failed");

// next-cycle implication, disabled in reset
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("random sample set check failed");

`endif

>>> sv/rss_pkg.sv
package rss_pkg;

  localparam int CAPACITY_DFLT = 64;

  localparam int ACT_W = 2;
  localparam int VAL_W = 32;
  localparam int RND_W = 32;
  localparam int ST_W  = 2;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_GET    = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOCHANGE = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

endpackage

>>> sv/rss_in_if.sv
interface rss_in_if import rss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  action_t                 action;
  logic signed [VAL_W-1:0] value;
  logic        [RND_W-1:0] random_word;

  modport source (output valid, action, value, random_word, input ready);
  modport sink   (input valid, action, value, random_word, output ready);
endinterface

>>> sv/rss_out_if.sv
interface rss_out_if import rss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] result_value;

  modport source (output valid, status, result_value, input ready);
  modport sink   (input valid, status, result_value, output ready);
endinterface

>>> sv/random_sample_set_unit.sv
// Random sample set unit.
// Holds a set of distinct signed 32-bit values in a dense store of CAPACITY
// entries. Each request on in_req carries an action (insert, remove, get
// random), a value and a random word; each request gives exactly one
// response on out_rsp with a status and, for a successful get random, the
// chosen element (otherwise zero).
// Both channels use valid/ready; a request is taken when both are high.
// One request is worked on at a time; in_req.ready is high only when idle.
// Insert and remove search the store one entry a cycle through the single
// memory read port; a remove that finds the value then moves the last entry
// into its slot before the response is given.
// Get random runs a 32-step restoring modulo unit (one bit a cycle), then
// one memory read at the remainder.
// Get random on an empty set and unused action codes answer with no search.
// The response sits in an output register; while out_rsp is stalled the
// next request is still taken and worked on, and its result holds in the
// final step until the output register frees.
// Reset (synchronous, active low) empties the set; the store contents are
// left as they are and need no clearing pass.
module random_sample_set_unit import rss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  rss_in_if.sink    in_req,
  rss_out_if.source out_rsp
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_MOVE_RD, S_MOVE_WR, S_MOD_WAIT, S_GET_DATA, S_DONE
  } state_t;

  state_t                  state_r;
  action_t                 act_r;
  logic signed [VAL_W-1:0] val_r;
  logic        [RND_W-1:0] rnd_r;
  logic [CNTW-1:0]         cnt_r;
  logic [CNTW-1:0]         scan_r;
  logic                    chk_vld_r;
  logic [IDXW-1:0]         chk_idx_r;
  logic [IDXW-1:0]         slot_r;
  status_t                 st_r;
  logic signed [VAL_W-1:0] res_r;
  logic                    out_vld_r;
  status_t                 out_st_r;
  logic signed [VAL_W-1:0] out_res_r;
  logic                    div_start_r;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;
  logic [IDXW-1:0]         rd_addr;
  logic [IDXW-1:0]         wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    wr_en;

  logic                    div_done;
  logic [CNTW-1:0]         div_rem;
  logic [CNTW-1:0]         last_idx;
  logic                    scan_lt;
  logic                    hit;
  logic                    miss;
  logic                    full;

  assign last_idx = cnt_r - CNTW'(1);
  assign scan_lt  = (scan_r < cnt_r);
  assign hit      = chk_vld_r && (rd_data_r == val_r);
  assign miss     = !chk_vld_r && !scan_lt;
  assign full     = (cnt_r == CNTW'(CAPACITY));

  rss_mod #(
    .DIVW (CNTW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (rnd_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    case (state_r)
      S_SEARCH:   rd_addr = scan_r[IDXW-1:0];
      S_MOVE_RD:  rd_addr = last_idx[IDXW-1:0];
      S_MOD_WAIT: rd_addr = div_rem[IDXW-1:0];
      default:    rd_addr = scan_r[IDXW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[IDXW-1:0];
    wr_data = val_r;
    case (state_r)
      S_SEARCH: begin
        wr_en = !hit && miss && (act_r == ACT_INSERT) && !full;
      end
      S_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_addr = slot_r;
        wr_data = rd_data_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_vld_r   <= 1'b0;
      chk_vld_r   <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_vld_r && out_rsp.ready && (state_r != S_DONE)) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            act_r     <= in_req.action;
            val_r     <= in_req.value;
            rnd_r     <= in_req.random_word;
            scan_r    <= '0;
            chk_vld_r <= 1'b0;
            res_r     <= '0;
            case (in_req.action)
              ACT_INSERT, ACT_REMOVE: state_r <= S_SEARCH;
              ACT_GET: begin
                if (cnt_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_DONE;
                end else begin
                  div_start_r <= 1'b1;
                  state_r     <= S_MOD_WAIT;
                end
              end
              default: begin
                st_r    <= ST_NOCHANGE;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: begin
          chk_vld_r <= scan_lt;
          chk_idx_r <= scan_r[IDXW-1:0];
          if (scan_lt) begin
            scan_r <= scan_r + CNTW'(1);
          end
          if (hit) begin
            slot_r <= chk_idx_r;
            if (act_r == ACT_INSERT) begin
              st_r    <= ST_NOCHANGE;
              state_r <= S_DONE;
            end else begin
              st_r    <= ST_OK;
              state_r <= S_MOVE_RD;
            end
          end else if (miss) begin
            state_r <= S_DONE;
            if (act_r != ACT_INSERT) begin
              st_r <= ST_NOCHANGE;
            end else if (full) begin
              st_r <= ST_FULL;
            end else begin
              st_r  <= ST_OK;
              cnt_r <= cnt_r + CNTW'(1);
            end
          end
        end
        S_MOVE_RD: state_r <= S_MOVE_WR;
        S_MOVE_WR: begin
          cnt_r   <= last_idx;
          state_r <= S_DONE;
        end
        S_MOD_WAIT: begin
          if (div_done) begin
            state_r <= S_GET_DATA;
          end
        end
        S_GET_DATA: begin
          res_r   <= rd_data_r;
          st_r    <= ST_OK;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_r || out_rsp.ready) begin
            out_vld_r <= 1'b1;
            out_st_r  <= st_r;
            out_res_r <= res_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.status       = out_st_r;
  assign out_rsp.result_value = out_res_r;

endmodule

>>> sv/rss_mod.sv
module rss_mod import rss_pkg::*; #(
  parameter int DIVW = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [DIVW-1:0]  divisor,
  output logic             done,
  output logic [DIVW-1:0]  rem
);

  localparam int SW = $clog2(RND_W);

  logic [RND_W-1:0] quo_r;
  logic [DIVW-1:0]  rem_r;
  logic [DIVW-1:0]  div_r;
  logic [SW-1:0]    step_r;
  logic             busy_r;
  logic             done_r;
  logic [DIVW:0]    trial;
  logic [DIVW:0]    diff;
  logic             fits;

  // one restoring step a cycle, quotient bits are not kept
  assign trial = {rem_r, quo_r[RND_W-1]};
  assign fits  = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        step_r <= SW'(RND_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r  <= {quo_r[RND_W-2:0], 1'b0};
        rem_r  <= fits ? diff[DIVW-1:0] : trial[DIVW-1:0];
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> sv/rss_checker.sv
`include "random_sample_set_unit_defines.svh"

module rss_checker import rss_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input status_t                 status,
  input logic signed [VAL_W-1:0] result_value
);

  // hold a stalled response
  `RSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_value))

  // busy once a request is taken
  `RSS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)

  // only a successful get random returns an element
  `RSS_ASSERT_IMPLY(a_value_needs_ok, clk, rst_n, out_valid && (result_value != '0), status == ST_OK)

endmodule

bind random_sample_set_unit rss_checker u_rss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .status       (out_rsp.status),
  .result_value (out_rsp.result_value)
);

>>> sim/random_sample_set_unit_checker.sv
module random_sample_set_unit_checker import rss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DFLT
) (
  input  logic clk,
  input  logic rst_n,
  rss_in_if    req_bus,
  rss_out_if   rsp_bus,
  output int   fail_count,
  output int   outstanding,
  output int   checked_count,
  output int   full_count
);

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] result_value;
  } response_t;

  logic signed [VAL_W-1:0] members [CAPACITY];
  int unsigned             member_count;
  response_t               expected_q [$];

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
    full_count    = 0;
    member_count  = 0;
  end

  function automatic response_t apply_request(action_t act, logic signed [VAL_W-1:0] val,
                                              logic [RND_W-1:0] rnd);
    response_t   rsp;
    int unsigned i;
    int unsigned slot;
    bit          found;
    rsp.status       = ST_NOCHANGE;
    rsp.result_value = '0;
    found            = 1'b0;
    slot             = 0;
    for (i = 0; i < member_count; i++) begin
      if (!found && members[i] == val) begin
        found = 1'b1;
        slot  = i;
      end
    end
    case (act)
      ACT_INSERT: begin
        if (found) begin
          rsp.status = ST_NOCHANGE;
        end else if (member_count >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          members[member_count] = val;
          member_count++;
          rsp.status = ST_OK;
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          // fill the hole with the last entry
          members[slot] = members[member_count - 1];
          member_count--;
          rsp.status = ST_OK;
        end
      end
      ACT_GET: begin
        if (member_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.result_value = members[rnd % member_count];
          rsp.status       = ST_OK;
        end
      end
      default: rsp.status = ST_NOCHANGE;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (rst_n) begin
      // match the response first so a stray one is never paired with a new request
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_q.size() == 0) begin
          $error("response with no request pending: status %0d result_value %0d",
                 rsp_bus.status, rsp_bus.result_value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_bus.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.result_value !== want.result_value) begin
            $error("result_value mismatch: expected %0d, actual %0d",
                   want.result_value, rsp_bus.result_value);
            fail_count++;
          end
          if (want.status == ST_FULL) full_count++;
          checked_count++;
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        expected_q.push_back(apply_request(req_bus.action, req_bus.value,
                                           req_bus.random_word));
      end
      outstanding = expected_q.size();
    end
  end

endmodule

>>> sim/random_sample_set_unit_test.sv
module random_sample_set_unit_test;
  import rss_pkg::*;

  localparam int      CAPACITY     = CAPACITY_DFLT;
  localparam int      REQ_TARGET   = 500;
  localparam int      POOL_SIZE    = CAPACITY + 8;
  localparam int      CYCLE_LIMIT  = 600000;
  localparam int      HOLD_CYCLES  = 400;
  localparam int      DRAIN_CYCLES = 120;
  localparam action_t ACT_UNUSED   = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic clk;
  logic rst_n;

  rss_in_if  in_req ();
  rss_out_if out_rsp ();

  int fail_count;
  int outstanding;
  int checked_count;
  int full_count;
  int cycles = 0;
  int sent [4];
  int total_sent;
  int burst_left;
  int fill_idx;
  int rx_mode;
  bit rsp_hold;
  bit hold_trigger;

  logic signed [VAL_W-1:0] pool [POOL_SIZE];

  random_sample_set_unit #(.CAPACITY(CAPACITY)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  random_sample_set_unit_checker #(.CAPACITY(CAPACITY)) set_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_bus       (in_req),
    .rsp_bus       (out_rsp),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run timed out with %0d responses outstanding", outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (rsp_hold) begin
      out_rsp.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_rsp.ready <= 1'b1;
        1:       out_rsp.ready <= 1'($urandom_range(0, 1));
        2:       out_rsp.ready <= ($urandom_range(0, 3) == 0);
        default: out_rsp.ready <= ((cycles % 8) < 5);
      endcase
    end
  end

  // long receiver hold-off, counted here while the sender keeps going
  initial begin
    rsp_hold = 1'b0;
    wait (hold_trigger);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold = 1'b0;
  end

  task automatic send_request(action_t act, logic signed [VAL_W-1:0] val,
                              logic [RND_W-1:0] rnd);
    @(negedge clk);
    in_req.valid       <= 1'b1;
    in_req.action      <= act;
    in_req.value       <= val;
    in_req.random_word <= rnd;
    do @(posedge clk); while (!in_req.ready);
    sent[act]++;
    total_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6)) begin
        @(negedge clk);
        in_req.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [RND_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(phase_t phase, int count);
    int                      pick;
    action_t                 act;
    logic signed [VAL_W-1:0] val;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      val  = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
      case (phase)
        PH_FILL: begin
          act = (pick < 80) ? ACT_INSERT : (pick < 92) ? ACT_GET :
                (pick < 97) ? ACT_REMOVE : ACT_UNUSED;
          if (act == ACT_INSERT) begin
            // walk the pool so the store reaches full
            val = pool[fill_idx % POOL_SIZE];
            fill_idx++;
          end
        end
        PH_DRAIN: begin
          act = (pick < 70) ? ACT_REMOVE : (pick < 90) ? ACT_GET :
                (pick < 95) ? ACT_INSERT : ACT_UNUSED;
        end
        default: begin
          act = (pick < 35) ? ACT_INSERT : (pick < 65) ? ACT_REMOVE :
                (pick < 95) ? ACT_GET : ACT_UNUSED;
        end
      endcase
      if (act == ACT_GET || act == ACT_UNUSED) val = $urandom;
      send_request(act, val, pick_word());
    end
  endtask

  initial begin
    phase_t order [6];
    int     step;
    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.action      = ACT_INSERT;
    in_req.value       = '0;
    in_req.random_word = '0;
    out_rsp.ready      = 1'b0;
    hold_trigger       = 1'b0;
    rx_mode            = 0;
    burst_left         = 0;
    fill_idx           = 0;
    total_sent         = 0;
    foreach (sent[i]) sent[i] = 0;
    pool[0] = VAL_MIN;
    pool[1] = VAL_MAX;
    pool[2] = '0;
    pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = $urandom;
    order = '{PH_FILL, PH_MIX, PH_DRAIN, PH_FILL, PH_DRAIN, PH_MIX};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(ACT_GET, '0, '1);
    send_request(ACT_REMOVE, VAL_MIN, '0);
    send_request(ACT_UNUSED, '1, '1);
    send_request(ACT_INSERT, VAL_MAX, '0);
    send_request(ACT_INSERT, VAL_MIN, '0);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, '1, '0);
    send_request(ACT_INSERT, VAL_MAX, '1);
    send_request(ACT_GET, VAL_MIN, '0);
    send_request(ACT_GET, VAL_MAX, '1);
    send_request(ACT_GET, '0, 32'h8000_0001);
    send_request(ACT_REMOVE, '1, '0);
    send_request(ACT_REMOVE, VAL_MAX, '0);
    send_request(ACT_REMOVE, 32'sh1234_5678, '0);
    send_request(ACT_GET, '0, 32'd7);
    send_request(ACT_UNUSED, '0, '0);
    send_request(ACT_REMOVE, VAL_MIN, '1);
    send_request(ACT_REMOVE, '0, '1);
    send_request(ACT_GET, '1, 32'h5555_aaaa);
    wait_quiet();

    step = 0;
    while (total_sent < REQ_TARGET) begin
      if (step == 1) hold_trigger = 1'b1;
      random_phase(order[step % 6], $urandom_range(60, 90));
      if (step % 2 == 1) wait_quiet();
      step++;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d insert, %0d remove, %0d get random, %0d unused code",
             total_sent, sent[ACT_INSERT], sent[ACT_REMOVE], sent[ACT_GET], sent[ACT_UNUSED]);
    $display("Checked %0d responses, %0d of them on a full store", checked_count, full_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rss_pkg.sv
sv/rss_in_if.sv
sv/rss_out_if.sv
sv/rss_mod.sv
sv/random_sample_set_unit.sv
sv/rss_checker.sv
sim/random_sample_set_unit_checker.sv
sim/random_sample_set_unit_test.sv
